### sv/zsmc_pkg.sv
// ----------------------------------------------------------------------------
// zsmc_pkg
// types and constants shared by the zip stamp masking compare block
// ----------------------------------------------------------------------------
package zsmc_pkg;

	typedef enum logic [2:0] {
		PH_DLC  = 3'd0,
		PH_LC   = 3'd1,
		PH_C    = 3'd2,
		PH_LH   = 3'd3,
		PH_CH   = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	localparam int OFF_W  = 6;
	localparam int SKIP_W = 34;

	localparam logic [31:0] SIG_LOCAL = 32'h504B0304;
	localparam logic [31:0] SIG_DESC  = 32'h504B0708;
	localparam logic [31:0] SIG_CENT  = 32'h504B0102;

	localparam int LOCAL_SIZE = 30;
	localparam int CENT_SIZE  = 46;
	localparam int DESC_SIZE  = 16;
	localparam int SIG_SIZE   = 4;

	localparam logic [OFF_W-1:0] LH_STAMP_LO = 6'd10;
	localparam logic [OFF_W-1:0] LH_STAMP_HI = 6'd14;
	localparam logic [OFF_W-1:0] LH_CSIZE    = 6'd18;
	localparam logic [OFF_W-1:0] LH_NAME     = 6'd26;
	localparam logic [OFF_W-1:0] LH_EXTRA    = 6'd28;
	localparam logic [OFF_W-1:0] LH_LAST     = 6'(LOCAL_SIZE - 1);

	localparam logic [OFF_W-1:0] CH_STAMP_LO = 6'd12;
	localparam logic [OFF_W-1:0] CH_STAMP_HI = 6'd16;
	localparam logic [OFF_W-1:0] CH_NAME     = 6'd28;
	localparam logic [OFF_W-1:0] CH_EXTRA    = 6'd30;
	localparam logic [OFF_W-1:0] CH_COMMENT  = 6'd32;
	localparam logic [OFF_W-1:0] CH_LAST     = 6'(CENT_SIZE - 1);

	localparam logic [OFF_W-1:0] SIG_LAST    = 6'(SIG_SIZE - 1);
	localparam logic [OFF_W-1:0] HDR_START   = 6'(SIG_SIZE);

	typedef struct packed {
		logic step;
		logic restart;
		logic desc_fit;
		logic local_fit;
		logic cent_fit;
	} lane_ctrl_t;

	typedef struct packed {
		logic stamp;
		logic sig_local;
	} lane_stat_t;

endpackage

### sv/zsmc_in_if.sv
// ----------------------------------------------------------------------------
// zsmc_in_if
// byte pair channel: one byte of each file per transaction
// ----------------------------------------------------------------------------
interface zsmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_a;
	logic [7:0] byte_b;

	modport source(output valid, output byte_a, output byte_b, input ready);
	modport sink(input valid, input byte_a, input byte_b, output ready);
endinterface

### sv/zsmc_out_if.sv
// ----------------------------------------------------------------------------
// zsmc_out_if
// result channel: one compare verdict per file pair
// ----------------------------------------------------------------------------
interface zsmc_out_if;
	logic valid;
	logic ready;
	logic files_differ;
	logic zip_rules_used;

	modport source(output valid, output files_differ, output zip_rules_used, input ready);
	modport sink(input valid, input files_differ, input zip_rules_used, output ready);
endinterface

### sv/zsmc_lane.sv
// ----------------------------------------------------------------------------
// zsmc_lane
// zip header walker for one file, flags time and date bytes of each header
// ----------------------------------------------------------------------------
module zsmc_lane
	import zsmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  logic [7:0] data,
	output lane_stat_t stat
);

	phase_t              phase_q, phase_n;
	logic [OFF_W-1:0]    off_q, off_n;
	logic [23:0]         win_q, win_n;
	logic [31:0]         csize_q, csize_n;
	logic [15:0]         nlen_q, nlen_n;
	logic [15:0]         elen_q, elen_n;
	logic [15:0]         clen_q, clen_n;
	logic [SKIP_W-1:0]   skip_q, skip_n;
	logic [31:0]         sig;

	assign sig = {win_q, data};

	always_comb begin
		stat.sig_local = (sig == SIG_LOCAL);
		stat.stamp     = 1'b0;
		if (phase_q == PH_LH) begin
			stat.stamp = (off_q >= LH_STAMP_LO) && (off_q < LH_STAMP_HI);
		end else if (phase_q == PH_CH) begin
			stat.stamp = (off_q >= CH_STAMP_LO) && (off_q < CH_STAMP_HI);
		end
	end

	always_comb begin
		phase_n = phase_q;
		off_n   = off_q;
		win_n   = win_q;
		csize_n = csize_q;
		nlen_n  = nlen_q;
		elen_n  = elen_q;
		clen_n  = clen_q;
		skip_n  = skip_q;
		if (ctrl.restart) begin
			phase_n = PH_LC;
			off_n   = '0;
			win_n   = '0;
			csize_n = '0;
			nlen_n  = '0;
			elen_n  = '0;
			clen_n  = '0;
			skip_n  = '0;
		end else if (ctrl.step) begin
			win_n = sig[23:0];
			unique case (phase_q)
				PH_DONE: begin
				end
				PH_LH: begin
					case (off_q)
						LH_CSIZE:         csize_n[7:0]   = data;
						LH_CSIZE + 6'd1:  csize_n[15:8]  = data;
						LH_CSIZE + 6'd2:  csize_n[23:16] = data;
						LH_CSIZE + 6'd3:  csize_n[31:24] = data;
						LH_NAME:          nlen_n[7:0]    = data;
						LH_NAME + 6'd1:   nlen_n[15:8]   = data;
						LH_EXTRA:         elen_n[7:0]    = data;
						LH_EXTRA + 6'd1:  elen_n[15:8]   = data;
						default: begin
						end
					endcase
					if (off_q >= LH_LAST) begin
						skip_n  = SKIP_W'(csize_n) + SKIP_W'(nlen_n) + SKIP_W'(elen_n);
						phase_n = PH_DLC;
						off_n   = '0;
					end else begin
						off_n = off_q + 6'd1;
					end
				end
				PH_CH: begin
					case (off_q)
						CH_NAME:            nlen_n[7:0]  = data;
						CH_NAME + 6'd1:     nlen_n[15:8] = data;
						CH_EXTRA:           elen_n[7:0]  = data;
						CH_EXTRA + 6'd1:    elen_n[15:8] = data;
						CH_COMMENT:         clen_n[7:0]  = data;
						CH_COMMENT + 6'd1:  clen_n[15:8] = data;
						default: begin
						end
					endcase
					if (off_q >= CH_LAST) begin
						skip_n  = SKIP_W'(nlen_n) + SKIP_W'(elen_n) + SKIP_W'(clen_n);
						phase_n = PH_C;
						off_n   = '0;
					end else begin
						off_n = off_q + 6'd1;
					end
				end
				PH_DLC, PH_LC, PH_C: begin
					if (skip_q != '0) begin
						skip_n = skip_q - SKIP_W'(1);
					end else if (off_q < SIG_LAST) begin
						off_n = off_q + 6'd1;
					end else begin
						off_n = '0;
						if (phase_q == PH_DLC && ctrl.desc_fit && sig == SIG_DESC) begin
							skip_n  = SKIP_W'(DESC_SIZE - SIG_SIZE);
							phase_n = PH_LC;
						end else if ((phase_q == PH_DLC || phase_q == PH_LC) &&
							ctrl.local_fit && sig == SIG_LOCAL) begin
							phase_n = PH_LH;
							off_n   = HDR_START;
							csize_n = '0;
							nlen_n  = '0;
							elen_n  = '0;
							clen_n  = '0;
						end else if (ctrl.cent_fit && sig == SIG_CENT) begin
							phase_n = PH_CH;
							off_n   = HDR_START;
							csize_n = '0;
							nlen_n  = '0;
							elen_n  = '0;
							clen_n  = '0;
						end else begin
							phase_n = PH_DONE;
						end
					end
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LC;
			off_q   <= '0;
			win_q   <= '0;
			csize_q <= '0;
			nlen_q  <= '0;
			elen_q  <= '0;
			clen_q  <= '0;
			skip_q  <= '0;
		end else begin
			phase_q <= phase_n;
			off_q   <= off_n;
			win_q   <= win_n;
			csize_q <= csize_n;
			nlen_q  <= nlen_n;
			elen_q  <= elen_n;
			clen_q  <= clen_n;
			skip_q  <= skip_n;
		end
	end

endmodule

### sv/zsmc_merge.sv
// ----------------------------------------------------------------------------
// zsmc_merge
// combines both lanes: masks stamp bytes, tracks mismatch, holds the result
// ----------------------------------------------------------------------------
module zsmc_merge
	import zsmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             last,
	input  logic             clear,
	input  logic             first_sig,
	input  logic [7:0]       byte_a,
	input  logic [7:0]       byte_b,
	input  lane_stat_t       stat_a,
	input  lane_stat_t       stat_b,
	zsmc_out_if.source       result
);

	logic       both_zip_q, both_zip_n;
	logic       mismatch_q, mismatch_n;
	logic       valid_q;
	logic       differ_q;
	logic       zip_q;
	logic [7:0] masked_a, masked_b;

	always_comb begin
		both_zip_n = first_sig ? (stat_a.sig_local && stat_b.sig_local) : both_zip_q;
		masked_a   = (both_zip_n && stat_a.stamp) ? 8'h00 : byte_a;
		masked_b   = (both_zip_n && stat_b.stamp) ? 8'h00 : byte_b;
		mismatch_n = mismatch_q || (masked_a != masked_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_zip_q <= 1'b0;
			mismatch_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (clear || (step && last)) begin
				both_zip_q <= 1'b0;
				mismatch_q <= 1'b0;
			end else if (step) begin
				both_zip_q <= both_zip_n;
				mismatch_q <= mismatch_n;
			end
			if (step && last) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			differ_q <= mismatch_n;
			zip_q    <= both_zip_n;
		end
	end

	assign result.valid          = valid_q;
	assign result.files_differ   = differ_q;
	assign result.zip_rules_used = zip_q;

endmodule

### sv/zip_stamp_masking_compare.sv
// ----------------------------------------------------------------------------
// zip_stamp_masking_compare
// zip aware compare of two equal-length files with time and date masked
// ----------------------------------------------------------------------------
// usage: write the byte count of each file on cfg_wr_en/cfg_wr_data while the
// block is idle; the write also restarts the comparison. then send one byte
// pair per transaction on pair, offset 0 first. a zero length drops all pairs.
// one transaction on result follows the pair at offset length-1; it arrives
// in the cycle after that pair is taken. pairs are taken one per cycle, save
// that the last pair of a file waits while the result channel stalls; both
// lane walkers and the compare update on each pair taken. after the last pair
// all stream state is cleared, so the next file pair can follow at once.
// reset clears the length to zero and puts both walkers before offset 0.
// while the result channel stalls, pairs keep flowing until the last pair of
// the next file, which waits until the held result is taken.
// ----------------------------------------------------------------------------
module zip_stamp_masking_compare
	import zsmc_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [LENGTH_BITS-1:0] cfg_wr_data,
	zsmc_in_if.sink                pair,
	zsmc_out_if.source             result
);

	localparam int EXT_W = LENGTH_BITS + 1;

	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [EXT_W-1:0]       pos_ext, len_ext;
	logic                   last;
	logic                   step;
	logic                   hold;
	lane_ctrl_t             ctrl;
	lane_stat_t             stat_a, stat_b;

	assign pos_ext = {1'b0, pos_q};
	assign len_ext = {1'b0, len_q};
	assign last    = (len_q != '0) && (pos_ext + EXT_W'(1) == len_ext);
	assign hold    = result.valid && !result.ready;
	assign pair.ready = !(hold && last);
	assign step    = pair.valid && pair.ready && (len_q != '0);

	always_comb begin
		ctrl.step      = step;
		ctrl.restart   = cfg_wr_en || (step && last);
		ctrl.desc_fit  = (pos_ext + EXT_W'(1)) < len_ext;
		ctrl.local_fit = (pos_ext + EXT_W'(LOCAL_SIZE - 3)) < len_ext;
		ctrl.cent_fit  = (pos_ext + EXT_W'(CENT_SIZE - 3)) < len_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
				pos_q <= '0;
			end else if (step) begin
				pos_q <= last ? '0 : pos_q + LENGTH_BITS'(1);
			end
		end
	end

	zsmc_lane u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.data   (pair.byte_a),
		.stat   (stat_a)
	);

	zsmc_lane u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.data   (pair.byte_b),
		.stat   (stat_b)
	);

	zsmc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last      (last),
		.clear     (cfg_wr_en),
		.first_sig (pos_q == LENGTH_BITS'(SIG_SIZE - 1)),
		.byte_a    (pair.byte_a),
		.byte_b    (pair.byte_b),
		.stat_a    (stat_a),
		.stat_b    (stat_b),
		.result    (result)
	);

endmodule
